>>> src/ppr_pkg.sv
package ppr_pkg;

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int TIME_W   = 32;
  localparam int GAP_W    = 16;
  localparam int RATE_W   = 10;
  localparam int MUL_W    = RATE_W + 1;
  localparam int PROD_W   = GAP_W + MUL_W;
  localparam int ENV_W    = 32;

  // beats-per-minute scale: 60000 ms per minute
  localparam int unsigned RATE_SCALE = 60000;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GAP      = 2'd0,
    CFG_RATE_FLOOR   = 2'd1,
    CFG_RATE_CEILING = 2'd2
  } cfg_idx_t;

  localparam logic [GAP_W-1:0]  MIN_GAP_RST      = 16'd300;
  localparam logic [RATE_W-1:0] RATE_FLOOR_RST   = 10'd40;
  localparam logic [RATE_W-1:0] RATE_CEILING_RST = 10'd200;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_ms;
  } in_req_t;

  typedef struct packed {
    logic             beat_found;
    logic [GAP_W-1:0] avg_rate;
    logic [GAP_W-1:0] last_gap_ms;
  } out_req_t;

  typedef struct packed {
    logic [GAP_W-1:0]  min_gap_ms;
    logic [RATE_W-1:0] rate_floor;
    logic [RATE_W-1:0] rate_ceiling;
  } cfg_regs_t;

  // one classified peak candidate handed to the back end
  typedef struct packed {
    logic             cand;
    logic [GAP_W-1:0] gap;
  } q_ent_t;

endpackage

>>> src/pulse_peak_rr_tracker.sv
// Pulse peak and RR interval tracker.
// Input channel: in_valid / in_stall carry one request of an intensity sample
// and its millisecond timestamp; a request is taken at a clock edge with
// in_valid high and in_stall low. Every request gives exactly one result on
// out_valid / out_stall: the beat flag, the average rate in beats per minute
// and the most recent stored RR interval.
// The front end updates the envelope and peak detector in the cycle a sample
// is taken and hands a classified request to a two-entry queue; the back end
// works on one request at a time. A request that is no peak candidate goes
// straight to output; a candidate is checked against the rate limits by the
// multiplier, and any stored interval but the first runs the bit-serial divider,
// W bits wide (the width of the interval sum, 19 for an 8-deep ring), for the
// mean and the rate. The cfg_ port writes min_gap_ms, rate_floor and
// rate_ceiling by index; the user is to do so only while the block is idle,
// which the block does not enforce. Synchronous reset restores the register
// defaults and clears detector, ring count and sum; the ring memory itself is
// not cleared. When out_stall is high the finished result waits in the output
// register and the back end holds; the queue then fills and in_stall rises.
module pulse_peak_rr_tracker #(
  parameter int RING_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  ppr_pkg::in_req_t                    in_data,
  output logic                                in_stall,
  output logic                                out_valid,
  output ppr_pkg::out_req_t                   out_data,
  input  logic                                out_stall,
  input  logic                                cfg_we,
  input  logic [ppr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ppr_pkg::*;

  cfg_regs_t cfg_r;
  logic      q_push;
  q_ent_t    q_wdata;
  logic      q_pop;
  q_ent_t    q_rdata;
  logic      q_full;
  logic      q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gap_ms   <= MIN_GAP_RST;
      cfg_r.rate_floor   <= RATE_FLOOR_RST;
      cfg_r.rate_ceiling <= RATE_CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_GAP:      cfg_r.min_gap_ms   <= cfg_wdata;
        CFG_RATE_FLOOR:   cfg_r.rate_floor   <= cfg_wdata[RATE_W-1:0];
        CFG_RATE_CEILING: cfg_r.rate_ceiling <= cfg_wdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ppr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cfg      (cfg_r),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  ppr_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ppr_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

>>> src/ppr_front.sv
module ppr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ppr_pkg::in_req_t  in_data,
  output logic              in_stall,
  input  ppr_pkg::cfg_regs_t cfg,
  output logic              q_push,
  output ppr_pkg::q_ent_t   q_wdata,
  input  logic              q_full
);
  import ppr_pkg::*;

  logic [SAMPLE_W-1:0] prev_level_r;
  logic                was_rising_r;
  logic                was_above_r;
  logic [ENV_W-1:0]    env_high_r;
  logic [ENV_W-1:0]    env_low_r;
  logic [TIME_W-1:0]   peak_stamp_r;

  logic [ENV_W-1:0]    level;
  logic [ENV_W-1:0]    hi_max;
  logic [ENV_W-1:0]    lo_min;
  logic [ENV_W:0]      env_sum;
  logic [ENV_W-1:0]    thr;
  logic [ENV_W-1:0]    env_high_nxt;
  logic [ENV_W-1:0]    env_low_nxt;
  logic                rising;
  logic                peak;
  logic [TIME_W-1:0]   gap;
  logic                cand;
  logic                accept;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;

  // envelope takes in the sample, threshold is the midpoint, then decay
  assign level        = {{(ENV_W-SAMPLE_W){1'b0}}, in_data.sample};
  assign hi_max       = (level > env_high_r) ? level : env_high_r;
  assign lo_min       = (level < env_low_r) ? level : env_low_r;
  assign env_sum      = {1'b0, hi_max} + {1'b0, lo_min};
  assign thr          = env_sum[ENV_W:1];
  assign env_high_nxt = hi_max - (hi_max >> 8);
  assign env_low_nxt  = lo_min + (lo_min >> 8);

  // peak: rising turned into not rising while above threshold
  assign rising = in_data.sample > prev_level_r;
  assign peak   = was_rising_r && !rising && was_above_r;

  // gaps above one minute can never meet the rate floor
  assign gap  = in_data.time_ms - peak_stamp_r;
  assign cand = peak && (gap > {{(TIME_W-GAP_W){1'b0}}, cfg.min_gap_ms})
                && (peak_stamp_r != '0) && (gap <= TIME_W'(RATE_SCALE));

  assign q_push        = accept;
  assign q_wdata.cand  = cand;
  assign q_wdata.gap   = gap[GAP_W-1:0];

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= '0;
      was_rising_r <= 1'b0;
      was_above_r  <= 1'b0;
      env_high_r   <= '0;
      env_low_r    <= '1;
      peak_stamp_r <= '0;
    end else if (accept) begin
      prev_level_r <= in_data.sample;
      was_rising_r <= rising;
      was_above_r  <= level > thr;
      env_high_r   <= env_high_nxt;
      env_low_r    <= env_low_nxt;
      if (peak) begin
        peak_stamp_r <= in_data.time_ms;
      end
    end
  end

endmodule

>>> src/ppr_fifo.sv
module ppr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ppr_pkg::q_ent_t wdata,
  input  logic            pop,
  output ppr_pkg::q_ent_t rdata,
  output logic            full,
  output logic            empty
);
  import ppr_pkg::*;

  q_ent_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;

  assign full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> src/ppr_div.sv
module ppr_div #(
  parameter int W = 19
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     num_r;
  logic [W-1:0]     den_r;
  logic [W-1:0]     rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [W:0]       trial;
  logic             fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, num_r[W-1]};
  assign fits  = trial >= {1'b0, den_r};

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? W'(trial - {1'b0, den_r}) : trial[W-1:0];
      num_r <= {num_r[W-2:0], fits};
    end
  end

endmodule

>>> src/ppr_back.sv
module ppr_back #(
  parameter int RING_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ppr_pkg::cfg_regs_t cfg,
  input  ppr_pkg::q_ent_t    q_rdata,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  output ppr_pkg::out_req_t  out_data,
  input  logic               out_stall
);
  import ppr_pkg::*;

  localparam int PTR_W  = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int TOT_W  = $clog2(RING_DEPTH * 60000 + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_CHECK,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_RATE_GO,
    S_RATE_WAIT,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [GAP_W-1:0]  gap_r;
  logic [PROD_W-1:0] prod_r;
  logic              lo_ok_r;
  logic [GAP_W-1:0]  ring_rd_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic [TOT_W-1:0]  total_r;
  logic [GAP_W-1:0]  last_gap_r;
  logic [GAP_W-1:0]  avg_r;
  logic [GAP_W-1:0]  mean_r;
  logic              beat_r;
  logic              out_valid_r;
  out_req_t          out_data_r;
  logic [GAP_W-1:0]  ring_mem [RING_DEPTH];

  logic [MUL_W-1:0]  floor_eff;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic              store;
  logic              full;
  logic [TOT_W-1:0]  old_gap;
  logic              div_start;
  logic [TOT_W-1:0]  div_num;
  logic [TOT_W-1:0]  div_den;
  logic              div_busy;
  logic              div_done;
  logic [TOT_W-1:0]  div_quo;
  logic              out_free;

  // rate limits as products: gap*floor <= 60000 and gap*(ceiling+1) > 60000
  assign floor_eff = (cfg.rate_floor == '0) ? MUL_W'(1) : {1'b0, cfg.rate_floor};
  assign mul_b     = (state_r == S_MUL_LO) ? floor_eff
                                           : ({1'b0, cfg.rate_ceiling} + MUL_W'(1));
  assign prod      = {{MUL_W{1'b0}}, gap_r} * {{GAP_W{1'b0}}, mul_b};
  assign store     = lo_ok_r && (prod_r > PROD_W'(RATE_SCALE));

  // oldest entry leaves the sum only once the ring is full
  assign full    = fill_r == FILL_W'(RING_DEPTH);
  assign old_gap = full ? {{(TOT_W-GAP_W){1'b0}}, ring_rd_r} : '0;

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared divider: mean interval, then rate from the mean
  assign div_start = (state_r == S_MEAN_GO) || ((state_r == S_RATE_GO) && (mean_r != '0));
  assign div_num   = (state_r == S_MEAN_GO) ? total_r : TOT_W'(RATE_SCALE);
  assign div_den   = (state_r == S_MEAN_GO) ? {{(TOT_W-FILL_W){1'b0}}, fill_r}
                                            : {{(TOT_W-GAP_W){1'b0}}, mean_r};

  ppr_div #(
    .W (TOT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // interval ring
  always_ff @(posedge clk) begin
    if (state_r == S_MUL_HI) begin
      ring_rd_r <= ring_mem[ptr_r];
    end
    if ((state_r == S_CHECK) && store) begin
      ring_mem[ptr_r] <= gap_r;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      last_gap_r  <= '0;
      avg_r       <= '0;
      beat_r      <= 1'b0;
      lo_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            gap_r   <= q_rdata.gap;
            beat_r  <= 1'b0;
            state_r <= q_rdata.cand ? S_MUL_LO : S_OUT;
          end
        end
        S_MUL_LO: begin
          prod_r  <= prod;
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          lo_ok_r <= prod_r <= PROD_W'(RATE_SCALE);
          prod_r  <= prod;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (store) begin
            beat_r     <= 1'b1;
            total_r    <= total_r - old_gap + {{(TOT_W-GAP_W){1'b0}}, gap_r};
            last_gap_r <= gap_r;
            ptr_r      <= (ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
            if (!full) begin
              fill_r <= fill_r + 1'b1;
            end
            // fewer than two intervals after this one keeps the average at zero
            state_r <= (fill_r != '0) ? S_MEAN_GO : S_OUT;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_MEAN_GO: begin
          state_r <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean_r  <= div_quo[GAP_W-1:0];
            state_r <= S_RATE_GO;
          end
        end
        S_RATE_GO: begin
          if (mean_r == '0) begin
            avg_r   <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_RATE_WAIT;
          end
        end
        S_RATE_WAIT: begin
          if (div_done) begin
            avg_r   <= div_quo[GAP_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.beat_found  <= beat_r;
            out_data_r.avg_rate    <= avg_r;
            out_data_r.last_gap_ms <= last_gap_r;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(RING_DEPTH))
    else $error("ring fill count above depth");

  a_beat_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.beat_found |-> out_data_r.last_gap_ms != '0)
    else $error("beat reported with zero interval");

  a_avg_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.avg_rate != '0) |-> fill_r >= FILL_W'(2))
    else $error("average rate with fewer than two intervals");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule
